>>> rtl/drrt_pkg.sv
// Shared types and constants for the duty ramp and reversal test core.
package drrt_pkg;

   // Fixed field widths of the transfer payloads and registers.
   localparam int DUTY_BITS       = 16;
   localparam int STEP_BITS       = 16;
   localparam int INTERVAL_BITS   = 16;
   localparam int PERIOD_BITS     = 20;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 20;

   // Saturation limits of the elapsed counters.
   localparam logic [INTERVAL_BITS-1:0] UPDATE_MAX   = '1;
   localparam logic [PERIOD_BITS-1:0]   REVERSAL_MAX = '1;

   // Reset values of the configuration registers.
   localparam logic [STEP_BITS-1:0]     SLEW_LIMIT_RESET      = 16'd30;
   localparam logic [INTERVAL_BITS-1:0] UPDATE_INTERVAL_RESET = 16'd20;
   localparam logic [PERIOD_BITS-1:0]   REVERSAL_PERIOD_RESET = 20'd5000;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SLEW_LIMIT      = 2'd0,
      CSR_UPDATE_INTERVAL = 2'd1,
      CSR_REVERSAL_PERIOD = 2'd2
   } csr_index_type;

   // Test sequencer phases.
   typedef enum logic [1:0] {
      PHASE_RUN  = 2'd0,
      PHASE_DOWN = 2'd1,
      PHASE_TURN = 2'd2
   } phase_type;

   // Input item.
   typedef struct packed {
      logic                 load_command;
      logic [DUTY_BITS-1:0] commanded_duty;
      logic                 commanded_dir;
      logic                 test_on;
   } req_payload_type;

   // Result item.
   typedef struct packed {
      logic                 applied_strobe;
      logic [DUTY_BITS-1:0] applied_duty;
      logic                 applied_dir;
      logic [1:0]           phase_out;
   } rsp_payload_type;

   // Current configuration handed from the register block to the step logic.
   typedef struct packed {
      logic [STEP_BITS-1:0]     slew_limit;
      logic [INTERVAL_BITS-1:0] update_interval_ms;
      logic [PERIOD_BITS-1:0]   reversal_period_ms;
   } cfg_type;

endpackage

>>> rtl/drrt_csr.sv
// Configuration registers of the duty ramp and reversal test core.
module drrt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [drrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [drrt_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output drrt_pkg::cfg_type                    cfg
);

   drrt_pkg::cfg_type cfg_ff;
   drrt_pkg::cfg_type cfg_in;
   logic              write_en;

   // Writes are always taken; an index beyond the register list is dropped.
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_index)
            drrt_pkg::CSR_SLEW_LIMIT:
               cfg_in.slew_limit = csr_data[drrt_pkg::STEP_BITS-1:0];
            drrt_pkg::CSR_UPDATE_INTERVAL:
               cfg_in.update_interval_ms = csr_data[drrt_pkg::INTERVAL_BITS-1:0];
            drrt_pkg::CSR_REVERSAL_PERIOD:
               cfg_in.reversal_period_ms = csr_data[drrt_pkg::PERIOD_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with reset defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_limit         <= drrt_pkg::SLEW_LIMIT_RESET;
         cfg_ff.update_interval_ms <= drrt_pkg::UPDATE_INTERVAL_RESET;
         cfg_ff.reversal_period_ms <= drrt_pkg::REVERSAL_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/drrt_step.sv
// Per-tick state update: command load, reversal test sequencer and duty ramp.
module drrt_step #(
   parameter int DUTY_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  drrt_pkg::req_payload_type req_data,
   input  drrt_pkg::cfg_type         cfg,
   output drrt_pkg::rsp_payload_type rsp_data
);

   logic [DUTY_WIDTH-1:0]                cur_ff, cur_in;
   logic [DUTY_WIDTH-1:0]                goal_ff, goal_in;
   logic                                 sense_ff, sense_in;
   drrt_pkg::phase_type                  phase_ff, phase_in;
   logic [drrt_pkg::INTERVAL_BITS-1:0]   upd_ff, upd_in;
   logic [drrt_pkg::PERIOD_BITS-1:0]     rev_ff, rev_in;

   logic [drrt_pkg::INTERVAL_BITS-1:0]   upd_inc;
   logic [drrt_pkg::PERIOD_BITS-1:0]     rev_inc;
   logic [DUTY_WIDTH-1:0]                goal_load;
   logic                                 sense_load;
   logic                                 fire;
   logic [drrt_pkg::DUTY_BITS-1:0]       cur_wide;
   logic [drrt_pkg::DUTY_BITS-1:0]       goal_wide;
   logic [drrt_pkg::DUTY_BITS-1:0]       ramp_wide;

   // Elapsed counters advance once per tick and saturate.
   assign upd_inc = (upd_ff != drrt_pkg::UPDATE_MAX)
                    ? upd_ff + drrt_pkg::INTERVAL_BITS'(1) : upd_ff;
   assign rev_inc = (rev_ff != drrt_pkg::REVERSAL_MAX)
                    ? rev_ff + drrt_pkg::PERIOD_BITS'(1) : rev_ff;

   // A strobed command replaces the goal and the direction.
   assign goal_load  = req_data.load_command
                       ? req_data.commanded_duty[DUTY_WIDTH-1:0] : goal_ff;
   assign sense_load = req_data.load_command ? req_data.commanded_dir : sense_ff;

   // Sequencer next phase.
   always_comb begin
      phase_in = drrt_pkg::PHASE_RUN;
      if (req_data.test_on) begin
         unique case (phase_ff)
            drrt_pkg::PHASE_RUN:
               phase_in = (rev_inc >= cfg.reversal_period_ms)
                          ? drrt_pkg::PHASE_DOWN : drrt_pkg::PHASE_RUN;
            drrt_pkg::PHASE_DOWN:
               phase_in = (cur_ff == '0) ? drrt_pkg::PHASE_TURN : drrt_pkg::PHASE_DOWN;
            drrt_pkg::PHASE_TURN:
               phase_in = drrt_pkg::PHASE_RUN;
            default:
               phase_in = drrt_pkg::PHASE_RUN;
         endcase
      end
   end

   // Sequencer actions on goal, direction and reversal timer.
   always_comb begin
      goal_in  = goal_load;
      sense_in = sense_load;
      rev_in   = rev_inc;
      if (req_data.test_on) begin
         unique case (phase_ff)
            drrt_pkg::PHASE_DOWN: goal_in = '0;
            drrt_pkg::PHASE_TURN: begin
               sense_in = ~sense_load;
               rev_in   = '0;
            end
            default: goal_in = goal_load;
         endcase
      end
   end

   // Ramp update: move toward the goal by at most one step, or snap to it.
   assign fire      = (upd_inc >= cfg.update_interval_ms);
   assign cur_wide  = drrt_pkg::DUTY_BITS'(cur_ff);
   assign goal_wide = drrt_pkg::DUTY_BITS'(goal_in);

   always_comb begin
      ramp_wide = cur_wide;
      if (cur_wide < goal_wide) begin
         ramp_wide = ((goal_wide - cur_wide) > cfg.slew_limit)
                     ? cur_wide + cfg.slew_limit : goal_wide;
      end else if (cur_wide > goal_wide) begin
         ramp_wide = ((cur_wide - goal_wide) > cfg.slew_limit)
                     ? cur_wide - cfg.slew_limit : goal_wide;
      end
   end

   assign cur_in = fire ? DUTY_WIDTH'(ramp_wide) : cur_ff;
   assign upd_in = fire ? '0 : upd_inc;

   // Result of this tick, reported from the next state.
   always_comb begin
      rsp_data.applied_strobe = fire;
      rsp_data.applied_duty   = drrt_pkg::DUTY_BITS'(cur_in);
      rsp_data.applied_dir    = sense_in;
      rsp_data.phase_out      = phase_in;
   end

   // State registers advance once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         goal_ff  <= '0;
         sense_ff <= 1'b0;
         phase_ff <= drrt_pkg::PHASE_RUN;
         upd_ff   <= '0;
         rev_ff   <= '0;
      end else if (accept) begin
         cur_ff   <= cur_in;
         goal_ff  <= goal_in;
         sense_ff <= sense_in;
         phase_ff <= phase_in;
         upd_ff   <= upd_in;
         rev_ff   <= rev_in;
      end
   end

   // Without an update the applied duty holds.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !fire) |=> $stable(cur_ff))
      else $error("applied duty moved without a ramp update");

   // An update clears the update timer.
   assert property (@(posedge clock) disable iff (reset)
      (accept && fire) |=> (upd_ff == '0))
      else $error("update timer not cleared after a ramp update");

   // A direction change restarts the reversal timer and returns the sequencer to run.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.test_on && (phase_ff == drrt_pkg::PHASE_TURN))
      |=> ((rev_ff == '0) && (phase_ff == drrt_pkg::PHASE_RUN)))
      else $error("direction change did not restart the reversal timer");

endmodule

>>> rtl/drrt_obuf.sv
// Result register with a skid stage between the step logic and the result channel.
module drrt_obuf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  drrt_pkg::rsp_payload_type in_data,
   output logic                      in_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output drrt_pkg::rsp_payload_type rsp_data
);

   logic                      out_valid_ff, out_valid_in;
   drrt_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic                      skid_valid_ff, skid_valid_in;
   drrt_pkg::rsp_payload_type skid_data_ff, skid_data_in;
   logic                      out_free;

   // The output slot can load when empty or when its transfer completes.
   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign in_stall = skid_valid_ff;

   // Fill the output slot from the skid first, keeping result order.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = in_valid;
            skid_data_in  = in_data;
         end else begin
            out_valid_in  = in_valid;
            out_data_in   = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // The skid only holds a result behind a waiting output result.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output slot is empty");

   // A stalled output result with no incoming transfer keeps the skid as is.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && !in_valid) |=> (skid_valid_ff == $past(skid_valid_ff)))
      else $error("skid occupancy changed during a full stall");

   // An incoming transfer is never accepted into a full buffer.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && out_valid_ff && rsp_stall) |-> !skid_valid_ff)
      else $error("result accepted while both slots are full");

endmodule

>>> rtl/duty_ramp_with_reversal_test_core.sv
// Top level of the slew-limited duty drive with a direction reversal test.
//
//   Channel   Direction  Handshake             Payload
//   req_*     in         req_valid/req_stall   drrt_pkg::req_payload_type
//   rsp_*     out        rsp_valid/rsp_stall   drrt_pkg::rsp_payload_type
//   csr_*     in         csr_valid/csr_ready   csr_index, csr_data
//
// One tick is accepted per clock cycle while req_stall is low; its result is
// registered in the output slot, or in the skid while an output result waits.
// The output register plus a one-entry skid let the block keep accepting
// while a result waits; req_stall rises only once both are occupied.
// Synchronous reset clears all state and loads the register defaults.
// Configuration writes are taken at any cycle.
module duty_ramp_with_reversal_test_core #(
   parameter int DUTY_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  drrt_pkg::req_payload_type            req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output drrt_pkg::rsp_payload_type            rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [drrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [drrt_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   drrt_pkg::cfg_type         cfg;
   drrt_pkg::rsp_payload_type step_data;
   logic                      accept;

   // An input transfer completes when valid and not stalled.
   assign accept = req_valid & ~req_stall;

   drrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   drrt_step #(
      .DUTY_WIDTH (DUTY_WIDTH)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg),
      .rsp_data (step_data)
   );

   drrt_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (step_data),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/duty_ramp_with_reversal_test_core_tb.sv
// Self-checking testbench for the duty ramp core with its reversal test sequencer.
`timescale 1ns / 100ps

module duty_ramp_with_reversal_test_core_tb;

   // Kinds of rows in the directed plan.
   typedef enum bit {
      ROW_TICK,
      ROW_CSR
   } plan_kind_type;

   typedef struct {
      plan_kind_type             kind;
      drrt_pkg::csr_index_type   reg_idx;
      logic [19:0]               value;
      drrt_pkg::req_payload_type tick;
      bit                        typed;
      drrt_pkg::rsp_payload_type want;
   } plan_row_type;

   localparam int RANDOM_PHASES    = 12;
   localparam int TICKS_PER_PHASE  = 140;
   localparam int RANDOM_TICKS     = RANDOM_PHASES * TICKS_PER_PHASE;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   drrt_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   drrt_pkg::rsp_payload_type rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [drrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [drrt_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Shadow copy of the configuration and of the drive state.
   logic [drrt_pkg::STEP_BITS-1:0]     cfg_step;
   logic [drrt_pkg::INTERVAL_BITS-1:0] cfg_interval;
   logic [drrt_pkg::PERIOD_BITS-1:0]   cfg_period;
   logic [drrt_pkg::DUTY_BITS-1:0]     duty_now;
   logic [drrt_pkg::DUTY_BITS-1:0]     duty_goal;
   logic                               sense;
   drrt_pkg::phase_type                phase;
   logic [drrt_pkg::INTERVAL_BITS-1:0] upd_cnt;
   logic [drrt_pkg::PERIOD_BITS-1:0]   rev_cnt;

   // Drive states that the core still owes, oldest first.
   drrt_pkg::rsp_payload_type expected_drive_q[$];
   plan_row_type              plan[$];

   int idle_mode = 0;
   int sender_quiet_left = 0;
   int rsp_quiet_left = 0;
   int tick_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int strobe_count = 0;
   int reversal_count = 0;
   int csr_write_count = 0;

   duty_ramp_with_reversal_test_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic drrt_pkg::rsp_payload_type drive(input bit s, input logic [15:0] d,
                                                       input bit dir,
                                                       input drrt_pkg::phase_type ph);
      drrt_pkg::rsp_payload_type r;
      r.applied_strobe = s;
      r.applied_duty   = d;
      r.applied_dir    = dir;
      r.phase_out      = ph;
      return r;
   endfunction

   function automatic plan_row_type tick_row(input bit ld, input logic [15:0] duty,
                                             input bit dir, input bit on);
      plan_row_type r;
      r.kind    = ROW_TICK;
      r.reg_idx = drrt_pkg::CSR_SLEW_LIMIT;
      r.value   = '0;
      r.typed   = 1'b0;
      r.want    = '0;
      r.tick.load_command   = ld;
      r.tick.commanded_duty = duty;
      r.tick.commanded_dir  = dir;
      r.tick.test_on        = on;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input bit ld, input logic [15:0] duty,
                                              input bit dir, input bit on,
                                              input drrt_pkg::rsp_payload_type want);
      plan_row_type r;
      r = tick_row(ld, duty, dir, on);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input drrt_pkg::csr_index_type idx,
                                            input logic [19:0] v);
      plan_row_type r;
      r = tick_row(1'b0, '0, 1'b0, 1'b0);
      r.kind    = ROW_CSR;
      r.reg_idx = idx;
      r.value   = v;
      return r;
   endfunction

   // One millisecond tick: load, sequencer, then the slew-limited update.
   function automatic drrt_pkg::rsp_payload_type next_drive_state(
      input drrt_pkg::req_payload_type t);
      drrt_pkg::rsp_payload_type r;
      bit fired;
      fired = 1'b0;
      if (upd_cnt != drrt_pkg::UPDATE_MAX) upd_cnt = upd_cnt + 16'd1;
      if (rev_cnt != drrt_pkg::REVERSAL_MAX) rev_cnt = rev_cnt + 20'd1;
      if (t.load_command) begin
         duty_goal = t.commanded_duty;
         sense     = t.commanded_dir;
      end
      if (!t.test_on) begin
         phase = drrt_pkg::PHASE_RUN;
      end else begin
         case (phase)
            drrt_pkg::PHASE_RUN: begin
               if (rev_cnt >= cfg_period) phase = drrt_pkg::PHASE_DOWN;
            end
            drrt_pkg::PHASE_DOWN: begin
               duty_goal = '0;
               if (duty_now == '0) phase = drrt_pkg::PHASE_TURN;
            end
            drrt_pkg::PHASE_TURN: begin
               sense   = ~sense;
               rev_cnt = '0;
               phase   = drrt_pkg::PHASE_RUN;
               reversal_count++;
            end
            default: begin
               phase = drrt_pkg::PHASE_RUN;
            end
         endcase
      end
      if (upd_cnt >= cfg_interval) begin
         upd_cnt = '0;
         fired   = 1'b1;
         if (duty_now < duty_goal) begin
            if (duty_goal - duty_now > cfg_step) duty_now = duty_now + cfg_step;
            else duty_now = duty_goal;
         end else if (duty_now > duty_goal) begin
            if (duty_now - duty_goal > cfg_step) duty_now = duty_now - cfg_step;
            else duty_now = duty_goal;
         end
      end
      r = drive(fired, duty_now, sense, phase);
      return r;
   endfunction

   // Presents one tick, with random sender gaps, and records what it must produce.
   task automatic send_tick(input drrt_pkg::req_payload_type t, input bit typed,
                            input drrt_pkg::rsp_payload_type want);
      drrt_pkg::rsp_payload_type model_out;
      int pct;
      pct = (idle_mode == 0) ? 10 : (idle_mode == 1) ? 86 : 0;
      if (csr_valid) csr_valid <= 1'b0;
      if (sender_quiet_left > 0) sender_quiet_left--;
      else if ($urandom_range(199) == 0) sender_quiet_left = 30;
      while (sender_quiet_left == 0 && $urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      model_out = next_drive_state(t);
      expected_drive_q.push_back(typed ? want : model_out);
      tick_count++;
   endtask

   // Holds the sender off until every owed result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input drrt_pkg::csr_index_type idx, input logic [19:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         drrt_pkg::CSR_SLEW_LIMIT: begin
            cfg_step = v[drrt_pkg::STEP_BITS-1:0];
         end
         drrt_pkg::CSR_UPDATE_INTERVAL: begin
            cfg_interval = v[drrt_pkg::INTERVAL_BITS-1:0];
         end
         drrt_pkg::CSR_REVERSAL_PERIOD: begin
            cfg_period = v[drrt_pkg::PERIOD_BITS-1:0];
         end
         default: begin
         end
      endcase
      csr_write_count++;
   endtask

   // Receiver back-pressure, with occasional stretches of none.
   always @(posedge clock) begin
      int pct;
      pct = (idle_mode == 0) ? 86 : (idle_mode == 1) ? 10 : 0;
      if (rsp_quiet_left != 0) rsp_quiet_left <= rsp_quiet_left - 1;
      else if ($urandom_range(255) == 0) rsp_quiet_left <= 40;
      rsp_stall <= (rsp_quiet_left == 0) && ($urandom_range(99) < pct);
   end

   // Compare every result transfer with the oldest owed drive state.
   always @(posedge clock) begin
      drrt_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drive_q.size() == 0) begin
            $display("%0t: unexpected result transfer, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_drive_q.pop_front();
            checked_count++;
            if (rsp_data.applied_strobe) strobe_count++;
            if (rsp_data.applied_strobe !== want.applied_strobe) begin
               $display("%0t: applied_strobe expected %b, actual %b", $time,
                        want.applied_strobe, rsp_data.applied_strobe);
               mismatch_count++;
            end
            if (rsp_data.applied_duty !== want.applied_duty) begin
               $display("%0t: applied_duty expected %h, actual %h", $time,
                        want.applied_duty, rsp_data.applied_duty);
               mismatch_count++;
            end
            if (rsp_data.applied_dir !== want.applied_dir) begin
               $display("%0t: applied_dir expected %b, actual %b", $time,
                        want.applied_dir, rsp_data.applied_dir);
               mismatch_count++;
            end
            if (rsp_data.phase_out !== want.phase_out) begin
               $display("%0t: phase_out expected %0d, actual %0d", $time,
                        want.phase_out, rsp_data.phase_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int lim;
      int sel;
      logic [15:0] s;
      logic [15:0] iv;
      logic [19:0] pr;
      drrt_pkg::req_payload_type t;

      // State after reset.
      cfg_step     = drrt_pkg::SLEW_LIMIT_RESET;
      cfg_interval = drrt_pkg::UPDATE_INTERVAL_RESET;
      cfg_period   = drrt_pkg::REVERSAL_PERIOD_RESET;
      duty_now     = '0;
      duty_goal    = '0;
      sense        = 1'b0;
      phase        = drrt_pkg::PHASE_RUN;
      upd_cnt      = '0;
      rev_cnt      = '0;

      // Directed plan: defaults, extreme steps, zero step, and the reversal sequence.
      plan.push_back(typed_row(1'b1, 16'hFFFF, 1'b1, 1'b0,
                               drive(1'b0, 16'h0000, 1'b1, drrt_pkg::PHASE_RUN)));
      plan.push_back(typed_row(1'b0, 16'h0000, 1'b0, 1'b0,
                               drive(1'b0, 16'h0000, 1'b1, drrt_pkg::PHASE_RUN)));
      plan.push_back(csr_row(drrt_pkg::CSR_SLEW_LIMIT, 20'd65535));
      plan.push_back(csr_row(drrt_pkg::CSR_UPDATE_INTERVAL, 20'd1));
      plan.push_back(typed_row(1'b0, 16'h0000, 1'b0, 1'b0,
                               drive(1'b1, 16'hFFFF, 1'b1, drrt_pkg::PHASE_RUN)));
      plan.push_back(typed_row(1'b1, 16'h0000, 1'b0, 1'b0,
                               drive(1'b1, 16'h0000, 1'b0, drrt_pkg::PHASE_RUN)));
      plan.push_back(csr_row(drrt_pkg::CSR_SLEW_LIMIT, 20'd0));
      plan.push_back(typed_row(1'b1, 16'h1234, 1'b1, 1'b0,
                               drive(1'b1, 16'h0000, 1'b1, drrt_pkg::PHASE_RUN)));
      plan.push_back(csr_row(drrt_pkg::CSR_SLEW_LIMIT, 20'd1));
      plan.push_back(csr_row(drrt_pkg::CSR_REVERSAL_PERIOD, 20'd1));
      plan.push_back(tick_row(1'b1, 16'h0003, 1'b0, 1'b1));
      // A load while ramping down is overridden by the forced zero goal.
      plan.push_back(tick_row(1'b1, 16'hFFFF, 1'b1, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));
      // Dropping the test enable sends the sequencer back to run.
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b0));
      plan.push_back(csr_row(drrt_pkg::CSR_UPDATE_INTERVAL, 20'd0));
      plan.push_back(csr_row(drrt_pkg::CSR_REVERSAL_PERIOD, 20'd0));
      plan.push_back(csr_row(drrt_pkg::CSR_SLEW_LIMIT, 20'd2));
      plan.push_back(tick_row(1'b1, 16'h0005, 1'b1, 1'b1));
      plan.push_back(tick_row(1'b0, 16'hAAAA, 1'b0, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h5555, 1'b1, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));
      plan.push_back(tick_row(1'b1, 16'h0001, 1'b1, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));
      plan.push_back(tick_row(1'b0, 16'h0000, 1'b0, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_idle();
            write_register(plan[i].reg_idx, plan[i].value);
         end else begin
            send_tick(plan[i].tick, plan[i].typed, plan[i].want);
         end
      end

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               s = 16'd1;     iv = 16'd1;     pr = 20'd1;
            end
            1: begin
               s = 16'd65535; iv = 16'd1;     pr = 20'd20;
            end
            2: begin
               s = 16'd0;     iv = 16'd2;     pr = 20'd10;
            end
            3: begin
               s = 16'd500;   iv = 16'd0;     pr = 20'd0;
            end
            4: begin
               s = 16'd30;    iv = 16'd65535; pr = 20'd1000000;
            end
            default: begin
               s  = 16'($urandom_range(2000, 1));
               iv = 16'($urandom_range(5, 1));
               pr = 20'($urandom_range(80, 2));
            end
         endcase
         wait_idle();
         write_register(drrt_pkg::CSR_SLEW_LIMIT, {4'd0, s});
         write_register(drrt_pkg::CSR_UPDATE_INTERVAL, {4'd0, iv});
         write_register(drrt_pkg::CSR_REVERSAL_PERIOD, pr);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            idle_mode = ((ph * TICKS_PER_PHASE + n) * 3) / RANDOM_TICKS;
            // Mostly goals that a reversal can ramp down in reasonable time.
            lim = (cfg_step == 0) ? 64 : int'(cfg_step) * 8;
            if (lim > 65535) lim = 65535;
            sel = int'($urandom_range(99));
            if (sel < 60) t.commanded_duty = 16'($urandom_range(lim, 0));
            else if (sel < 85) t.commanded_duty = 16'($urandom_range(65535, 0));
            else t.commanded_duty = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            t.load_command  = ($urandom_range(99) < 20);
            t.commanded_dir = 1'($urandom_range(1));
            t.test_on       = ($urandom_range(99) < 90);
            send_tick(t, 1'b0, '0);
            // One mid-phase pause until the core has delivered everything.
            if (ph == 6 && n == 70) wait_idle();
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("Ran %0d ticks through %0d register writes; %0d results checked.",
               tick_count, csr_write_count, checked_count);
      $display("Saw %0d ramp updates and %0d test direction reversals.",
               strobe_count, reversal_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
